/* hw/rtl/jfe_pkg.sv */
// ----------------------------------------------------------------------------
// jfe_pkg
// Shared types and constants for the JSON unsigned integer field extractor:
// byte classes passed from the front to the back, parse phases, characters
// and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package jfe_pkg;

  // Register file geometry.
  localparam int KEY_CHARS = 16;
  localparam int KEY_BITS  = 8 * KEY_CHARS;
  localparam int LEN_W     = 5;
  localparam int SEEN_W    = 5;
  localparam int VALUE_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_BRACE = 8'h7D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Parse phases of the back end.
  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_PRE_COLON,
    PH_POST_COLON,
    PH_DIGITS,
    PH_ACCEPT,
    PH_FAIL
  } phase_t;

  // One classified byte, as queued between front and back.
  typedef struct packed {
    logic       key_hit;    // quoted key completed on this byte
    logic       colon;
    logic       space;
    logic       term;       // comma or closing brace
    logic       digit;
    logic [3:0] digit_val;
    logic       last;       // final byte of the message
  } byte_class_t;

endpackage

`default_nettype wire

/* hw/rtl/json_uint64_field_extractor.sv */
// ----------------------------------------------------------------------------
// json_uint64_field_extractor
// Finds a configured quoted key in a byte stream and returns the unsigned
// decimal integer that follows its colon, one result per message.
//
//   Channel  Handshake             Payload
//   in       in_valid / in_ready   text_byte, final_byte
//   out      out_valid / out_ready extract_ok, number_value
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte is accepted per cycle while in_ready is high; the result register of a
// message loads at the edge where its final byte leaves the queue, which holds it in a register after its transfer.
// The front end window compare and the back end times-ten add are combinational.
// Reset clears the queue, search and parse state and loads key_length with 1.
// When the result is not taken, the back end holds the next final byte and the
// two-entry queue fills before in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module json_uint64_field_extractor #(
  parameter int KEY_MAX = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [7:0]                      text_byte,
  input  wire logic                            final_byte,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 extract_ok,
  output logic [jfe_pkg::VALUE_W-1:0]          number_value,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [jfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jfe_pkg::VALUE_W-1:0]     cfg_data
);

  logic [jfe_pkg::VALUE_W-1:0] key_bytes_low;
  logic [jfe_pkg::VALUE_W-1:0] key_bytes_high;
  logic [jfe_pkg::LEN_W-1:0]   key_length;
  logic                        in_fire;
  jfe_pkg::byte_class_t        front_cls;
  jfe_pkg::byte_class_t        q_data;
  logic                        q_valid;
  logic                        q_ready;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes_low  <= '0;
      key_bytes_high <= '0;
      key_length     <= jfe_pkg::LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jfe_pkg::CFG_KEY_LOW:  key_bytes_low  <= cfg_data;
        jfe_pkg::CFG_KEY_HIGH: key_bytes_high <= cfg_data;
        jfe_pkg::CFG_KEY_LEN:  key_length     <= cfg_data[jfe_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: window search and byte classification.
  jfe_front #(
    .KEY_MAX (KEY_MAX)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .text_byte  (text_byte),
    .final_byte (final_byte),
    .key_bytes  ({key_bytes_high, key_bytes_low}),
    .key_length (key_length),
    .cls        (front_cls)
  );

  // Queue between the two ends.
  jfe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (front_cls),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  // Back end: parse phases, accumulation and result register.
  jfe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .extract_ok   (extract_ok),
    .number_value (number_value)
  );

endmodule

`default_nettype wire

/* hw/rtl/jfe_front.sv */
// ----------------------------------------------------------------------------
// jfe_front
// Front end: keeps the sliding window of recent bytes, detects the first
// quoted key of each message and classifies every byte for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jfe_front #(
  parameter int KEY_MAX = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         fire,
  input  wire logic [7:0]                   text_byte,
  input  wire logic                         final_byte,
  input  wire logic [jfe_pkg::KEY_BITS-1:0] key_bytes,
  input  wire logic [jfe_pkg::LEN_W-1:0]    key_length,
  output jfe_pkg::byte_class_t              cls
);

  // Longest key that can ever match.
  localparam int LMAX = (KEY_MAX < jfe_pkg::KEY_CHARS) ? KEY_MAX : jfe_pkg::KEY_CHARS;

  logic [7:0]                  win [0:LMAX];
  logic [jfe_pkg::SEEN_W-1:0]  bytes_seen;
  logic [jfe_pkg::SEEN_W-1:0]  bytes_seen_next;
  logic                        found;
  logic [LMAX:1]               len_hit;
  logic [LMAX:1]               len_sel;
  logic                        seen_ok;
  logic                        match;

  // Per key length: the stored bytes hold an opening quote and the key.
  for (genvar gl = 1; gl <= LMAX; gl++) begin : g_len
    logic [gl-1:0] kc;
    for (genvar gk = 0; gk < gl; gk++) begin : g_chr
      assign kc[gk] = (win[gl-1-gk] == key_bytes[8*gk +: 8]);
    end
    assign len_hit[gl] = (win[gl] == jfe_pkg::CH_QUOTE) && (&kc);
    assign len_sel[gl] = (key_length == jfe_pkg::LEN_W'(gl));
  end

  // Saturating byte count including the current byte.
  assign bytes_seen_next = (&bytes_seen) ? bytes_seen : bytes_seen + 1'b1;
  assign seen_ok = ({1'b0, bytes_seen_next} >= ({1'b0, key_length} + 6'd2));

  // The current byte closes the quoted key.
  assign match = !found && (text_byte == jfe_pkg::CH_QUOTE) && seen_ok &&
                 (|(len_hit & len_sel));

  // Byte classification.
  always_comb begin
    cls.key_hit   = match;
    cls.colon     = (text_byte == jfe_pkg::CH_COLON);
    cls.space     = (text_byte == jfe_pkg::CH_SPACE) || (text_byte == jfe_pkg::CH_TAB) ||
                    (text_byte == jfe_pkg::CH_CR) || (text_byte == jfe_pkg::CH_LF);
    cls.term      = (text_byte == jfe_pkg::CH_COMMA) || (text_byte == jfe_pkg::CH_BRACE);
    cls.digit     = (text_byte >= jfe_pkg::CH_ZERO) && (text_byte <= jfe_pkg::CH_NINE);
    cls.digit_val = text_byte[3:0];
    cls.last      = final_byte;
  end

  // Search control; cleared at the end of every message.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      found      <= 1'b0;
    end else if (fire) begin
      if (final_byte) begin
        bytes_seen <= '0;
        found      <= 1'b0;
      end else if (!found) begin
        bytes_seen <= bytes_seen_next;
        found      <= match;
      end
    end
  end

  // Window shift line; entries are only trusted once counted in bytes_seen.
  always_ff @(posedge clk) begin
    if (fire && !found) begin
      win[0] <= text_byte;
      for (int i = 1; i <= LMAX; i++) begin
        win[i] <= win[i-1];
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jfe_queue.sv */
// ----------------------------------------------------------------------------
// jfe_queue
// Short register queue of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module jfe_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push_valid,
  output logic                      push_ready,
  input  wire jfe_pkg::byte_class_t push_data,
  output logic                      pop_valid,
  input  wire logic                 pop_ready,
  output jfe_pkg::byte_class_t      pop_data
);

  localparam int DEPTH = jfe_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jfe_pkg::byte_class_t slots [DEPTH];
  logic [PTR_W-1:0]     wr_ptr;
  logic [PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]     count;
  logic                 push;
  logic                 pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jfe_back.sv */
// ----------------------------------------------------------------------------
// jfe_back
// Back end: runs the parse phase machine on classified bytes, accumulates
// the decimal value and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jfe_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_valid,
  output logic                             q_ready,
  input  wire jfe_pkg::byte_class_t        q_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             extract_ok,
  output logic [jfe_pkg::VALUE_W-1:0]      number_value
);

  localparam int W = jfe_pkg::VALUE_W;

  jfe_pkg::phase_t phase;
  jfe_pkg::phase_t phase_next;
  logic [W-1:0]    acc;
  logic [W-1:0]    acc_next;
  logic [W+3:0]    acc_x10;
  logic            overflow;
  logic            pop;
  logic            ok_next;

  // A last byte can only leave when the output register is free or being emptied.
  assign q_ready = !q_data.last || !out_valid || out_ready;
  assign pop     = q_valid && q_ready;

  // Times ten plus digit, as shift and add.
  assign acc_x10  = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{W{1'b0}}, q_data.digit_val};
  assign overflow = |acc_x10[W+3:W];

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (phase)
      jfe_pkg::PH_SEARCH: begin
        if (q_data.key_hit) phase_next = jfe_pkg::PH_PRE_COLON;
      end
      jfe_pkg::PH_PRE_COLON: begin
        if (q_data.colon) phase_next = jfe_pkg::PH_POST_COLON;
        else if (!q_data.space) phase_next = jfe_pkg::PH_FAIL;
      end
      jfe_pkg::PH_POST_COLON: begin
        if (q_data.digit) phase_next = jfe_pkg::PH_DIGITS;
        else if (!q_data.space) phase_next = jfe_pkg::PH_FAIL;
      end
      jfe_pkg::PH_DIGITS: begin
        if (q_data.digit) begin
          if (overflow) phase_next = jfe_pkg::PH_FAIL;
        end else if (q_data.term || q_data.space) begin
          phase_next = jfe_pkg::PH_ACCEPT;
        end else begin
          phase_next = jfe_pkg::PH_FAIL;
        end
      end
      default: phase_next = phase;
    endcase
  end

  // Value update.
  always_comb begin
    acc_next = acc;
    unique case (phase)
      jfe_pkg::PH_POST_COLON: begin
        if (q_data.digit) acc_next = {{(W-4){1'b0}}, q_data.digit_val};
      end
      jfe_pkg::PH_DIGITS: begin
        if (q_data.digit && !overflow) acc_next = acc_x10[W-1:0];
      end
      default: acc_next = acc;
    endcase
  end

  assign ok_next = (phase_next == jfe_pkg::PH_DIGITS) || (phase_next == jfe_pkg::PH_ACCEPT);

  // Phase and value; both return to the start at the end of a message.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jfe_pkg::PH_SEARCH;
      acc   <= '0;
    end else if (pop) begin
      if (q_data.last) begin
        phase <= jfe_pkg::PH_SEARCH;
        acc   <= '0;
      end else begin
        phase <= phase_next;
        acc   <= acc_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_data.last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      extract_ok   <= ok_next;
      number_value <= ok_next ? acc_next : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/jfe_checker.sv */
// ----------------------------------------------------------------------------
// jfe_checker
// Port-level checks for the field extractor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module jfe_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          extract_ok,
  input wire logic [jfe_pkg::VALUE_W-1:0]   number_value,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(number_value) && $stable(extract_ok))
    else $error("result changed while stalled");

  // A failed extraction reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !extract_ok |-> number_value == '0)
    else $error("failed result carries a nonzero value");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // Configuration transfers are never stalled.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind json_uint64_field_extractor jfe_checker u_jfe_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .extract_ok   (extract_ok),
  .number_value (number_value),
  .cfg_valid    (cfg_valid),
  .cfg_ready    (cfg_ready)
);

`default_nettype wire
